@@ hw/rtl/xewd_pkg.sv @@
// Shared types, character codes and helper functions for the XML entity
// and whitespace decoder. No dependencies; used by every module of the block.
package xewd_pkg;

    localparam int XEWD_MAX_OUT     = 8;
    localparam int XEWD_CNT_W       = 4;
    localparam int XEWD_QUEUE_DEPTH = 2;

    // character codes
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // named entity identifiers
    localparam logic [2:0] ENT_AMP  = 3'd0;
    localparam logic [2:0] ENT_APOS = 3'd1;
    localparam logic [2:0] ENT_QUOT = 3'd2;
    localparam logic [2:0] ENT_GT   = 3'd3;
    localparam logic [2:0] ENT_LT   = 3'd4;

    // decoded bytes of one input item
    typedef struct packed {
        logic [XEWD_MAX_OUT-1:0][7:0] bytes;
        logic [XEWD_CNT_W-1:0]        cnt;
        logic                         err;
        logic                         last;
    } t_pkt;

    // output buffer under construction, with the held-back space
    typedef struct packed {
        logic [XEWD_MAX_OUT-1:0][7:0] bytes;
        logic [XEWD_CNT_W-1:0]        cnt;
        logic                         pend;
    } t_obuf;

    // text of each named entity after the '&'
    function automatic logic [7:0] xewd_ent_char(logic [2:0] id, logic [2:0] k);
        logic [7:0] ch;
        ch = CH_NUL;
        case (id)
            ENT_AMP: begin
                case (k)
                    3'd0: ch = 8'h61;
                    3'd1: ch = 8'h6D;
                    3'd2: ch = 8'h70;
                    3'd3: ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            ENT_APOS: begin
                case (k)
                    3'd0: ch = 8'h61;
                    3'd1: ch = 8'h70;
                    3'd2: ch = 8'h6F;
                    3'd3: ch = 8'h73;
                    3'd4: ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            ENT_QUOT: begin
                case (k)
                    3'd0: ch = 8'h71;
                    3'd1: ch = 8'h75;
                    3'd2: ch = 8'h6F;
                    3'd3: ch = 8'h74;
                    3'd4: ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            ENT_GT: begin
                case (k)
                    3'd0: ch = 8'h67;
                    3'd1: ch = 8'h74;
                    3'd2: ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
            default: begin
                case (k)
                    3'd0: ch = 8'h6C;
                    3'd1: ch = 8'h74;
                    3'd2: ch = CH_SEMI;
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

    // decoded value of a completed named entity
    function automatic logic [7:0] xewd_ent_value(logic [2:0] id, logic bracket);
        logic [7:0] v;
        case (id)
            ENT_AMP:  v = CH_AMP;
            ENT_APOS: v = 8'h27;
            ENT_QUOT: v = 8'h22;
            ENT_GT:   v = bracket ? 8'h5D : 8'h3E;
            default:  v = bracket ? 8'h5B : 8'h3C;
        endcase
        return v;
    endfunction

    // append one byte, drop it once the buffer is full
    function automatic t_obuf xewd_push(t_obuf ob, logic [7:0] b);
        t_obuf r;
        r = ob;
        if (r.cnt < XEWD_CNT_W'(XEWD_MAX_OUT)) begin
            r.bytes[r.cnt[$clog2(XEWD_MAX_OUT)-1:0]] = b;
            r.cnt = r.cnt + 1'b1;
        end
        return r;
    endfunction

    // emit a byte through the trailing-space hold
    function automatic t_obuf xewd_emit(t_obuf ob, logic [7:0] b);
        t_obuf r;
        r = ob;
        if (r.pend) begin
            r = xewd_push(r, CH_SPACE);
            r.pend = 1'b0;
        end
        if (b == CH_SPACE) begin
            r.pend = 1'b1;
        end else begin
            r = xewd_push(r, b);
        end
        return r;
    endfunction

    // emit a 16-bit code as one to three UTF-8 bytes
    function automatic t_obuf xewd_utf8(t_obuf ob, logic [15:0] code);
        t_obuf r;
        r = ob;
        if (code < 16'h0080) begin
            r = xewd_emit(r, code[7:0]);
        end else if (code < 16'h0800) begin
            r = xewd_emit(r, {3'b110, code[10:6]});
            r = xewd_emit(r, {2'b10, code[5:0]});
        end else begin
            r = xewd_emit(r, {4'b1110, code[15:12]});
            r = xewd_emit(r, {2'b10, code[11:6]});
            r = xewd_emit(r, {2'b10, code[5:0]});
        end
        return r;
    endfunction

    // emit '&' and the letters of a partial named entity
    function automatic t_obuf xewd_flush(t_obuf ob, logic [15:0] acc);
        t_obuf      r;
        logic [2:0] id;
        logic [2:0] k;
        r  = ob;
        id = (acc[5:3] > 3'd4) ? 3'd4 : acc[5:3];
        k  = (acc[2:0] > 3'd4) ? 3'd4 : acc[2:0];
        r  = xewd_emit(r, CH_AMP);
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < k) begin
                r = xewd_emit(r, xewd_ent_char(id, 3'(i)));
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/xewd_front.sv @@
// Front end: accepts input bytes, runs the entity and whitespace state
// machine and builds the decoded bytes of each item. Depends on xewd_pkg.
module xewd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_byte,
    input  logic               i_last_in,
    input  logic               i_q_full,
    output logic               o_q_push,
    output xewd_pkg::t_pkt     o_pkt
);
    import xewd_pkg::*;

    typedef enum logic [3:0] {
        MS_IDLE,
        MS_AMP,
        MS_NAME,
        MS_HASH,
        MS_DEC,
        MS_HEX
    } t_match;

    t_match      r_ms, n_ms;
    logic [15:0] r_acc, n_acc;
    logic        r_pend, n_pend;
    logic        r_run, n_run;
    logic        r_drop, n_drop;
    logic        r_bracket;

    t_obuf       ob;
    logic        do_plain;
    logic [2:0]  id;
    logic [2:0]  k;
    logic        is_dig;
    logic        hv_ok;
    logic [3:0]  hv;
    logic        accept;

    assign o_in_ready = ~i_q_full;
    assign accept     = i_in_valid & o_in_ready;

    // classify the byte
    always_comb begin
        is_dig = (i_in_byte >= 8'h30) && (i_in_byte <= 8'h39);
        hv_ok  = 1'b1;
        hv     = i_in_byte[3:0];
        if (is_dig) begin
            hv = i_in_byte[3:0];
        end else if ((i_in_byte >= 8'h61 && i_in_byte <= 8'h66) ||
                     (i_in_byte >= 8'h41 && i_in_byte <= 8'h46)) begin
            hv = i_in_byte[3:0] + 4'd9;
        end else begin
            hv_ok = 1'b0;
        end
        id = (r_acc[5:3] > 3'd4) ? 3'd4 : r_acc[5:3];
        k  = (r_acc[2:0] > 3'd4) ? 3'd4 : r_acc[2:0];
    end

    // decode one item
    always_comb begin
        n_ms     = r_ms;
        n_acc    = r_acc;
        n_run    = r_run;
        n_drop   = r_drop;
        ob       = '0;
        ob.pend  = r_pend;
        do_plain = 1'b0;

        if (!r_drop) begin
            case (r_ms)
                MS_AMP: begin
                    if (i_in_byte == CH_A) begin
                        n_ms  = MS_NAME;
                        n_acc = {10'd0, ENT_AMP, 3'd1};
                    end else if (i_in_byte == CH_Q) begin
                        n_ms  = MS_NAME;
                        n_acc = {10'd0, ENT_QUOT, 3'd1};
                    end else if (i_in_byte == CH_G) begin
                        n_ms  = MS_NAME;
                        n_acc = {10'd0, ENT_GT, 3'd1};
                    end else if (i_in_byte == CH_L) begin
                        n_ms  = MS_NAME;
                        n_acc = {10'd0, ENT_LT, 3'd1};
                    end else if (i_in_byte == CH_HASH) begin
                        n_ms  = MS_HASH;
                        n_acc = '0;
                    end else begin
                        ob       = xewd_emit(ob, CH_AMP);
                        n_ms     = MS_IDLE;
                        do_plain = 1'b1;
                    end
                end
                MS_NAME: begin
                    if (k == 3'd1 && id == ENT_AMP && i_in_byte == CH_P) begin
                        n_acc = {10'd0, ENT_APOS, 3'd2};
                    end else if (i_in_byte == xewd_ent_char(id, k)) begin
                        if (i_in_byte == CH_SEMI) begin
                            ob    = xewd_emit(ob, xewd_ent_value(id, r_bracket));
                            n_ms  = MS_IDLE;
                            n_acc = '0;
                        end else begin
                            n_acc = {10'd0, id, k + 3'd1};
                        end
                    end else begin
                        ob       = xewd_flush(ob, r_acc);
                        n_ms     = MS_IDLE;
                        n_acc    = '0;
                        do_plain = 1'b1;
                    end
                end
                MS_HASH, MS_DEC, MS_HEX: begin
                    if (r_ms == MS_HASH && i_in_byte == CH_X) begin
                        n_ms  = MS_HEX;
                        n_acc = '0;
                    end else if (r_ms == MS_HASH && is_dig) begin
                        n_ms  = MS_DEC;
                        n_acc = {12'd0, i_in_byte[3:0]};
                    end else if (r_ms == MS_DEC && is_dig) begin
                        n_acc = 16'(r_acc * 16'd10) + {12'd0, i_in_byte[3:0]};
                    end else if (r_ms == MS_HEX && hv_ok) begin
                        n_acc = {r_acc[11:0], hv};
                    end else begin
                        // code ends: send it, flag a missing semicolon
                        ob    = xewd_utf8(ob, r_acc);
                        n_acc = '0;
                        n_ms  = MS_IDLE;
                        if (i_in_byte != CH_SEMI) begin
                            n_drop  = 1'b1;
                            ob.pend = 1'b0;
                        end
                    end
                end
                default: begin
                    n_ms     = MS_IDLE;
                    do_plain = 1'b1;
                end
            endcase

            // ordinary text byte
            if (do_plain) begin
                if (i_in_byte == CH_AMP) begin
                    n_run = 1'b0;
                    n_ms  = MS_AMP;
                    n_acc = '0;
                end else if (i_in_byte == CH_SPACE || i_in_byte == CH_TAB) begin
                    if (!r_run) begin
                        ob    = xewd_emit(ob, CH_SPACE);
                        n_run = 1'b1;
                    end
                end else begin
                    n_run = 1'b0;
                    if (i_in_byte != CH_CR && i_in_byte != CH_LF) begin
                        ob = xewd_emit(ob, i_in_byte);
                    end
                end
            end
        end

        // close an entity left open at the end of the string
        if (i_last_in) begin
            if (!n_drop) begin
                case (n_ms)
                    MS_AMP: ob = xewd_emit(ob, CH_AMP);
                    MS_NAME: ob = xewd_flush(ob, n_acc);
                    MS_HASH, MS_DEC, MS_HEX: begin
                        ob      = xewd_utf8(ob, n_acc);
                        n_drop  = 1'b1;
                        ob.pend = 1'b0;
                    end
                    default: ob = ob;
                endcase
            end
            ob.pend = 1'b0;
        end

        n_pend = ob.pend;
    end

    assign o_pkt.bytes = ob.bytes;
    assign o_pkt.cnt   = ob.cnt;
    assign o_pkt.err   = n_drop;
    assign o_pkt.last  = i_last_in;

    // queue only items that produce results
    assign o_q_push = accept & ((ob.cnt != '0) | i_last_in);

    // hold match state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms      <= MS_IDLE;
            r_acc     <= '0;
            r_pend    <= 1'b0;
            r_run     <= 1'b0;
            r_drop    <= 1'b0;
            r_bracket <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bracket <= i_cfg_wr_data;
            end
            if (accept) begin
                if (i_last_in) begin
                    r_ms   <= MS_IDLE;
                    r_acc  <= '0;
                    r_pend <= 1'b0;
                    r_run  <= 1'b0;
                    r_drop <= 1'b0;
                end else begin
                    r_ms   <= n_ms;
                    r_acc  <= n_acc;
                    r_pend <= n_pend;
                    r_run  <= n_run;
                    r_drop <= n_drop;
                end
            end
        end
    end

endmodule

@@ hw/rtl/xewd_queue.sv @@
// Short queue of decoded items between front and back end.
// Depends on xewd_pkg for the item type.
module xewd_queue #(
    parameter int DEPTH = xewd_pkg::XEWD_QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  xewd_pkg::t_pkt               i_pkt,
    input  logic                         i_pop,
    output xewd_pkg::t_pkt               o_head,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import xewd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // store incoming items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/xewd_back.sv @@
// Back end: walks the bytes of the head item, one result per cycle while
// the output is not stalled, into an output register. Depends on xewd_pkg.
module xewd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xewd_pkg::t_pkt     i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_end_of_string,
    output logic               o_entity_error
);
    import xewd_pkg::*;

    localparam int IW = $clog2(XEWD_MAX_OUT);

    logic [IW-1:0] r_idx;
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_bv;
    logic          r_eos;
    logic          r_err;
    logic [IW-1:0] last_idx;
    logic          has_bytes;
    logic          load;
    logic          at_end;

    assign has_bytes = (i_head.cnt != '0);
    assign last_idx  = has_bytes ? IW'(i_head.cnt - 1'b1) : '0;
    assign at_end    = (r_idx == last_idx);
    assign load      = ~i_empty & (~r_ov | i_out_ready);
    assign o_pop     = load & at_end;

    // load the next result, drop the item after its final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else if (load) begin
            r_ov  <= 1'b1;
            r_idx <= at_end ? '0 : r_idx + 1'b1;
        end else if (i_out_ready) begin
            r_ov  <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= has_bytes ? i_head.bytes[r_idx] : 8'h00;
            r_bv   <= has_bytes;
            r_eos  <= i_head.last & at_end;
            r_err  <= i_head.err;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_out_byte      = r_byte;
    assign o_byte_valid    = r_bv;
    assign o_end_of_string = r_eos;
    assign o_entity_error  = r_err;

endmodule

@@ hw/rtl/xml_entity_whitespace_decoder.sv @@
// Top level of the XML entity and whitespace decoder: front end, item
// queue and back end. Depends on xewd_pkg, xewd_front, xewd_queue, xewd_back.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   config   | i_cfg_wr_en                | i_cfg_wr_data (bracket mode)
//   input    | i_in_valid / o_in_ready    | i_in_byte, i_last_in
//   output   | o_out_valid / i_out_ready  | o_out_byte, o_byte_valid,
//            |                            | o_end_of_string, o_entity_error
//
// The front end decodes one input byte per cycle and is ready whenever the
// item queue has room. The back end gives one result per cycle while the
// output is ready; an item gives max(1, decoded bytes) results, up to 8;
// items with no result skip the queue. Items are registered in the queue,
// then in the back-end output register. Reset is synchronous and clears
// all control state; output stalls fill the queue and then drop ready.
module xml_entity_whitespace_decoder #(
    parameter int QUEUE_DEPTH = xewd_pkg::XEWD_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_string,
    output logic       o_entity_error
);
    import xewd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_pkt          front_pkt;
    t_pkt          head_pkt;
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    logic [CW-1:0] q_count;

    xewd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .i_last_in     (i_last_in),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_pkt         (front_pkt)
    );

    xewd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pkt   (front_pkt),
        .i_pop   (q_pop),
        .o_head  (head_pkt),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    xewd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_pkt),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_entity_error  (o_entity_error)
    );

`ifndef SYNTHESIS
    // an empty result only closes a string
    a_empty_is_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_end_of_string)
        else $error("empty result without end of string");

    // an empty result carries a zero byte
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_out_byte == 8'h00)
        else $error("empty result with non-zero byte");

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("item queue overflow");

    // a pushed item is always taken by the queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");
`endif

endmodule

@@ tb/sv/tb_xml_entity_whitespace_decoder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for xml_entity_whitespace_decoder: directed and random strings
// go through a valid/ready driver, and each result is compared with a byte-level decoder.
// Depends on xewd_pkg and the decoder RTL only.
module tb_xml_entity_whitespace_decoder;
    import xewd_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 4;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 76;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_STEP_BYTES  = 8;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [2:0] {M_IDLE, M_AMP, M_NAME, M_HASH, M_DEC, M_HEX} t_match;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } t_text_item;

    typedef struct {
        logic [7:0] data;
        logic       has_byte;
        logic       eos;
        logic       err;
    } t_decoded;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_in_byte     = 8'h00;
    logic       i_last_in     = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_end_of_string;
    logic       o_entity_error;

    xml_entity_whitespace_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_last_in       (i_last_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_entity_error  (o_entity_error)
    );

    // entity names after the '&', indexed by entity id
    string ent_text [5] = '{"amp;", "apos;", "quot;", "gt;", "lt;"};

    // decoder state mirrored in the testbench
    logic        bracket_sel = 1'b0;
    t_match      mstate      = M_IDLE;
    logic [15:0] code_acc    = 16'h0000;
    logic [2:0]  name_id     = ENT_AMP;
    int          name_len    = 0;
    logic        space_held  = 1'b0;
    logic        in_blank_run = 1'b0;
    logic        err_drop    = 1'b0;
    logic [7:0]  step_bytes[$];

    t_decoded    decoded_q[$];
    t_text_item  text_q[$];
    logic [7:0]  str_buf[$];
    t_text_item  next_item;

    int send_idle_pct  = 20;
    int recv_idle_pct  = 78;
    int queued_count   = 0;
    int accepted_count = 0;
    int results_seen   = 0;
    int strings_sent   = 0;
    int fail_count     = 0;
    int unsigned cycle_count = 0;
    logic in_taken = 1'b0;

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // byte decoder
    // ------------------------------------------------------------------

    function automatic void store_char(logic [7:0] b);
        if (step_bytes.size() < MAX_STEP_BYTES) begin
            step_bytes.push_back(b);
        end
    endfunction

    // hold back a space until a further byte follows
    function automatic void emit_char(logic [7:0] b);
        if (space_held) begin
            store_char(CH_SPACE);
            space_held = 1'b0;
        end
        if (b == CH_SPACE) begin
            space_held = 1'b1;
        end else begin
            store_char(b);
        end
    endfunction

    // send '&' and the letters matched so far
    function automatic void flush_name();
        emit_char(CH_AMP);
        for (int i = 0; i < name_len; i++) begin
            emit_char(ent_text[name_id][i]);
        end
    endfunction

    // send the code as UTF-8; without ';' drop the rest of the string
    function automatic void finish_numeric(logic closed);
        if (code_acc < 16'h0080) begin
            emit_char(code_acc[7:0]);
        end else if (code_acc < 16'h0800) begin
            emit_char({3'b110, code_acc[10:6]});
            emit_char({2'b10, code_acc[5:0]});
        end else begin
            emit_char({4'b1110, code_acc[15:12]});
            emit_char({2'b10, code_acc[11:6]});
            emit_char({2'b10, code_acc[5:0]});
        end
        code_acc = 16'h0000;
        mstate   = M_IDLE;
        if (!closed) begin
            err_drop   = 1'b1;
            space_held = 1'b0;
        end
    endfunction

    // ordinary text: entity start, blank runs, line breaks
    function automatic void plain_char(logic [7:0] c);
        if (c == CH_AMP) begin
            in_blank_run = 1'b0;
            mstate       = M_AMP;
            code_acc     = 16'h0000;
        end else if (c == CH_SPACE || c == CH_TAB) begin
            if (!in_blank_run) begin
                emit_char(CH_SPACE);
                in_blank_run = 1'b1;
            end
        end else begin
            in_blank_run = 1'b0;
            if (c != CH_CR && c != CH_LF) begin
                emit_char(c);
            end
        end
    endfunction

    function automatic void feed_byte(logic [7:0] c);
        int d;
        case (mstate)
            M_AMP: begin
                if (c == CH_A || c == CH_Q || c == CH_G || c == CH_L) begin
                    mstate   = M_NAME;
                    name_len = 1;
                    name_id  = (c == CH_A) ? ENT_AMP : (c == CH_Q) ? ENT_QUOT :
                               (c == CH_G) ? ENT_GT : ENT_LT;
                end else if (c == CH_HASH) begin
                    mstate   = M_HASH;
                    code_acc = 16'h0000;
                end else begin
                    emit_char(CH_AMP);
                    mstate = M_IDLE;
                    plain_char(c);
                end
            end
            M_NAME: begin
                if (name_len == 1 && name_id == ENT_AMP && c == CH_P) begin
                    // "&ap" turns the match over to apos
                    name_id  = ENT_APOS;
                    name_len = 2;
                end else if (c == ent_text[name_id][name_len]) begin
                    if (c == CH_SEMI) begin
                        case (name_id)
                            ENT_AMP:  emit_char(CH_AMP);
                            ENT_APOS: emit_char("'");
                            ENT_QUOT: emit_char("\"");
                            ENT_GT:   emit_char(bracket_sel ? "]" : ">");
                            default:  emit_char(bracket_sel ? "[" : "<");
                        endcase
                        mstate = M_IDLE;
                    end else begin
                        name_len++;
                    end
                end else begin
                    flush_name();
                    mstate = M_IDLE;
                    plain_char(c);
                end
            end
            M_HASH: begin
                if (c == CH_X) begin
                    mstate   = M_HEX;
                    code_acc = 16'h0000;
                end else if (c >= "0" && c <= "9") begin
                    mstate   = M_DEC;
                    code_acc = 16'(c) - 16'h30;
                end else begin
                    finish_numeric(c == CH_SEMI);
                end
            end
            M_DEC: begin
                if (c >= "0" && c <= "9") begin
                    code_acc = code_acc * 16'd10 + 16'(c) - 16'h30;
                end else begin
                    finish_numeric(c == CH_SEMI);
                end
            end
            M_HEX: begin
                if (c >= "0" && c <= "9") d = c - 8'h30;
                else if (c >= "a" && c <= "f") d = c - 8'h57;
                else if (c >= "A" && c <= "F") d = c - 8'h37;
                else d = -1;
                if (d >= 0) begin
                    code_acc = code_acc * 16'd16 + 16'(d);
                end else begin
                    finish_numeric(c == CH_SEMI);
                end
            end
            default: begin
                mstate = M_IDLE;
                plain_char(c);
            end
        endcase
    endfunction

    // decode one accepted byte and queue the results it causes
    function automatic void decode_input_byte(logic [7:0] c, logic last);
        t_decoded r;
        int       n;
        step_bytes.delete();
        if (!err_drop) begin
            feed_byte(c);
        end
        if (last) begin
            if (!err_drop) begin
                case (mstate)
                    M_AMP:                 emit_char(CH_AMP);
                    M_NAME:                flush_name();
                    M_HASH, M_DEC, M_HEX:  finish_numeric(1'b0);
                    default: ;
                endcase
            end
            space_held = 1'b0;
        end
        n = step_bytes.size();
        for (int i = 0; i < n; i++) begin
            r.data     = step_bytes[i];
            r.has_byte = 1'b1;
            r.eos      = last && (i == n - 1);
            r.err      = err_drop;
            decoded_q.push_back(r);
        end
        if (last) begin
            if (n == 0) begin
                r.data     = 8'h00;
                r.has_byte = 1'b0;
                r.eos      = 1'b1;
                r.err      = err_drop;
                decoded_q.push_back(r);
            end
            mstate       = M_IDLE;
            code_acc     = 16'h0000;
            name_len     = 0;
            space_held   = 1'b0;
            in_blank_run = 1'b0;
            err_drop     = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // check results, record accepted items
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result: byte %02h valid %b eos %b err %b",
                                 o_out_byte, o_byte_valid, o_end_of_string, o_entity_error);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.data || o_byte_valid !== want.has_byte ||
                        o_end_of_string !== want.eos || o_entity_error !== want.err) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            // fields in order: byte, valid, end of string, error
                            $display(
                                "result %0d mismatch: exp %02h %b %b %b, got %02h %b %b %b",
                                results_seen, want.data, want.has_byte, want.eos,
                                want.err, o_out_byte, o_byte_valid,
                                o_end_of_string, o_entity_error);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                decode_input_byte(i_in_byte, i_last_in);
                accepted_count++;
                in_taken = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // input driver: hold the item until taken, then idle or present the next
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_in_valid && !in_taken) begin
            // hold
        end else if (text_q.size() != 0 && !(text_q[0].drain && decoded_q.size() != 0) &&
                     (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct)) begin
            next_item = text_q.pop_front();
            i_in_valid <= 1'b1;
            i_in_byte  <= next_item.data;
            i_last_in  <= next_item.last;
        end else begin
            i_in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // output back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic add_byte(logic [7:0] b);
        str_buf.push_back(b);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            str_buf.push_back(s[i]);
        end
    endtask

    // queue the collected string, last flag on its final byte
    task automatic send_string(logic drain);
        t_text_item it;
        for (int i = 0; i < str_buf.size(); i++) begin
            it.data  = str_buf[i];
            it.last  = (i == str_buf.size() - 1);
            it.drain = drain && (i == 0);
            text_q.push_back(it);
            queued_count++;
        end
        str_buf.delete();
        strings_sent++;
    endtask

    // numeric code across the 1, 2 and 3 byte UTF-8 ranges, with wrap-around
    function automatic int pick_code();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 127);
            1:       return 32;
            2:       return $urandom_range(128, 2047);
            3:       return $urandom_range(2048, 65535);
            default: return $urandom_range(65536, 99999);
        endcase
    endfunction

    function automatic string hex_text(int v);
        string s;
        s = $sformatf("%0h", v);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] >= "a" && $urandom_range(0, 1)) begin
                s[i] = s[i] - 8'h20;
            end
        end
        return s;
    endfunction

    // mostly well-formed text and entities, some noise and broken entities
    task automatic add_random_string();
        int         tokens;
        int         kind;
        int         id;
        int         n;
        logic [7:0] b;
        string      term;
        term   = "Xg &.";
        tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++) begin
            kind = $urandom_range(0, 99);
            id   = $urandom_range(0, 4);
            if (kind < 28) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(33, 126));
                    add_byte((b == CH_AMP) ? CH_P : b);
                end
            end else if (kind < 42) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 5))
                        3:       add_byte(CH_TAB);
                        4:       add_byte(CH_CR);
                        5:       add_byte(CH_LF);
                        default: add_byte(CH_SPACE);
                    endcase
                end
            end else if (kind < 60) begin
                add_text({"&", ent_text[id]});
            end else if (kind < 68) begin
                add_byte(CH_AMP);
                n = $urandom_range(0, ent_text[id].len() - 1);
                for (int i = 0; i < n; i++) begin
                    add_byte(ent_text[id][i]);
                end
            end else if (kind < 78) begin
                // now and then a leading zero
                if ($urandom_range(0, 5) == 0) begin
                    add_text("&#0");
                end else begin
                    add_text("&#");
                end
                add_text({$sformatf("%0d", pick_code()), ";"});
            end else if (kind < 88) begin
                add_text({"&#x", hex_text(pick_code()), ";"});
            end else if (kind < 95) begin
                case ($urandom_range(0, 4))
                    0: begin
                        add_text({"&#", $sformatf("%0d", pick_code())});
                        add_byte(term[$urandom_range(0, 4)]);
                    end
                    1: begin
                        add_text({"&#x", hex_text(pick_code())});
                        add_byte(term[$urandom_range(0, 4)]);
                    end
                    2:       add_text("&#X41;");
                    3:       add_text("&#;");
                    default: add_text("&#x;");
                endcase
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // wait until every item is taken and every result is back, then settle
    task automatic wait_idle();
        while (accepted_count != queued_count || decoded_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_bracket_mode(logic mode);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        bracket_sel = mode;
    endtask

    initial begin
        int   send_tab [NUM_PHASES];
        int   recv_tab [NUM_PHASES];
        logic mode_tab [NUM_PHASES];
        int   phase_start;
        logic drained;
        send_tab = '{20, 20, 78, 78, 0, 0};
        recv_tab = '{78, 78, 20, 20, 0, 0};
        mode_tab = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

        // reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_bracket_mode(mode_tab[p]);
            send_idle_pct = send_tab[p];
            recv_idle_pct = recv_tab[p];
            phase_start   = queued_count;

            if (p == 0) begin
                // extreme bytes, lt/gt, trailing space
                add_byte(8'hFF);
                add_text("&lt;&gt; ");
                send_string(1'b0);
                // string ends inside a hex entity
                add_text("&#x41");
                send_string(1'b0);
                // partial apos, then a NUL byte
                add_text("&ap");
                add_byte(8'h00);
                send_string(1'b0);
                // decimal entity closed by a letter: error, rest dropped
                add_text("&#65X");
                send_string(1'b0);
                // CR splits a blank run; only one space comes out, the trailing one is dropped
                add_text(" \r ");
                send_string(1'b0);
                // final byte that yields nothing
                add_text("\n");
                send_string(1'b0);
            end

            drained = 1'b0;
            while (queued_count - phase_start < ITEMS_PER_PHASE) begin
                add_random_string();
                // once per phase, hold the next string until the block has drained
                send_string(!drained && (queued_count - phase_start > ITEMS_PER_PHASE / 2));
                if (queued_count - phase_start > ITEMS_PER_PHASE / 2) begin
                    drained = 1'b1;
                end
            end
        end

        wait_idle();
        fail_count += decoded_q.size();
        $display("%0d bytes in %0d strings driven, %0d results compared", accepted_count,
                 strings_sent, results_seen);
        $display("both bracket settings, sender/receiver idle 20/78, 78/20 and none");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/xewd_pkg.sv
hw/rtl/xewd_front.sv
hw/rtl/xewd_queue.sv
hw/rtl/xewd_back.sv
hw/rtl/xml_entity_whitespace_decoder.sv
tb/sv/tb_xml_entity_whitespace_decoder.sv
